### hdl/efs_pkg.sv
// Shared constants for the earliest-free-server scheduler.
package efs_pkg;

  localparam int MAX_SERVERS_DEF = 8;
  localparam int TIME_BITS_DEF   = 24;
  localparam int DUR_W           = 10;
  localparam int CFG_W           = 4;
  localparam logic [CFG_W-1:0] SERVER_COUNT_RESET = CFG_W'(1);

endpackage

### hdl/efs_ifs.sv
// Valid/ready channel interfaces for jobs, results and the server-count register.
interface efs_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [efs_pkg::CFG_W-1:0] server_count;

  modport source (output valid, output server_count, input ready);
  modport sink   (input valid, input server_count, output ready);
endinterface

interface efs_job_if;
  logic                      valid;
  logic                      ready;
  logic                      new_batch;
  logic [efs_pkg::DUR_W-1:0] duration;

  modport source (output valid, output new_batch, output duration, input ready);
  modport sink   (input valid, input new_batch, input duration, output ready);
endinterface

interface efs_result_if #(
  parameter int IDX_W  = 3,
  parameter int TIME_W = efs_pkg::TIME_BITS_DEF
);
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  server_index;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] finish_time;
  logic [TIME_W-1:0] makespan;
  logic              saturated;

  modport source (output valid, output server_index, output start_time, output finish_time,
                  output makespan, output saturated, input ready);
  modport sink   (input valid, input server_index, input start_time, input finish_time,
                  input makespan, input saturated, output ready);
endinterface

### hdl/earliest_free_server_scheduler_core.sv
// Earliest-free-server list scheduler: top level.
// Takes one job per clock and assigns it to the active server with the lowest free
// time (lowest index on a tie); the result appears in the output register in the cycle
// after the job transfer. Sustained rate is one job per cycle while results are taken,
// set by the combinational path from the registered free times through the min-select
// and one saturating add. The job channel stalls only in reset and while a finished
// result waits untaken in the output register. Servers 1 and up at or above server_count
// are skipped; a new_batch job clears all times, makespan and saturation flag first.
module earliest_free_server_scheduler_core #(
  parameter int MAX_SERVERS = efs_pkg::MAX_SERVERS_DEF,
  parameter int TIME_BITS   = efs_pkg::TIME_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  efs_cfg_if.sink        cfg,
  efs_job_if.sink        job,
  efs_result_if.source   result
);

  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

  logic [efs_pkg::CFG_W-1:0] server_count;
  logic [TIME_BITS-1:0]      free_time [MAX_SERVERS];
  logic [TIME_BITS-1:0]      makespan;
  logic                      overflow_seen;

  logic [TIME_BITS-1:0]      base_time [MAX_SERVERS];
  logic [TIME_BITS-1:0]      base_makespan;
  logic                      base_overflow;
  logic [IDX_W-1:0]          best;
  logic [TIME_BITS-1:0]      best_time;
  logic [TIME_BITS:0]        sum;
  logic                      sum_over;
  logic [TIME_BITS-1:0]      finish;
  logic [TIME_BITS-1:0]      makespan_next;
  logic                      overflow_next;

  logic                      out_valid;
  logic                      job_xfer;

  assign cfg.ready = !rst;
  assign job.ready = !rst && (!out_valid || result.ready);
  assign job_xfer  = job.valid && job.ready;

  always_comb begin
    for (int s = 0; s < MAX_SERVERS; s++) begin
      base_time[s] = job.new_batch ? '0 : free_time[s];
    end
    base_makespan = job.new_batch ? '0 : makespan;
    base_overflow = job.new_batch ? 1'b0 : overflow_seen;

    best      = '0;
    best_time = base_time[0];
    for (int s = 1; s < MAX_SERVERS; s++) begin
      if (s < int'(server_count) && base_time[s] < best_time) begin
        best      = IDX_W'(s);
        best_time = base_time[s];
      end
    end

    sum      = {1'b0, best_time} + (TIME_BITS + 1)'(job.duration);
    sum_over = sum[TIME_BITS];
    finish   = sum_over ? '1 : sum[TIME_BITS-1:0];

    makespan_next = (finish > base_makespan) ? finish : base_makespan;
    overflow_next = base_overflow || sum_over;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      server_count  <= efs_pkg::SERVER_COUNT_RESET;
      makespan      <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
      for (int s = 0; s < MAX_SERVERS; s++) begin
        free_time[s] <= '0;
      end
    end else begin
      if (cfg.valid && cfg.ready) begin
        server_count <= cfg.server_count;
      end
      if (job_xfer) begin
        for (int s = 0; s < MAX_SERVERS; s++) begin
          free_time[s] <= (IDX_W'(s) == best) ? finish : base_time[s];
        end
        makespan      <= makespan_next;
        overflow_seen <= overflow_next;
        out_valid     <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_xfer) begin
      result.server_index <= best;
      result.start_time   <= best_time;
      result.finish_time  <= finish;
      result.makespan     <= makespan_next;
      result.saturated    <= overflow_next;
    end
  end

  assign result.valid = out_valid;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    job_xfer |=> result.valid)
    else $error("result missing after job transfer");

  a_makespan_covers: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.makespan >= result.finish_time)
    else $error("makespan below finish time");

  a_finish_after_start: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.finish_time >= result.start_time)
    else $error("finish before start");

  a_new_batch_first: assert property (@(posedge clk) disable iff (rst)
    (job_xfer && job.new_batch) |=> (result.start_time == '0 && result.server_index == '0))
    else $error("new batch job not placed on server zero at time zero");

endmodule
